// ===== rtl/elgamal_cipher_core_unit_macros.svh =====
// assertion macros for the elgamal cipher core
`ifndef ELGAMAL_CIPHER_CORE_UNIT_MACROS_SVH
`define ELGAMAL_CIPHER_CORE_UNIT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define EGC_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define EGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/egc_pkg.sv =====
// shared types and constants for the elgamal cipher core
package egc_pkg;

    localparam int MOD_BITS_DEF = 32;
    localparam int DATA_W       = 32;
    localparam int CMD_W        = 2;
    localparam int IDX_W        = 2;

    localparam logic [DATA_W-1:0] MODULUS_RST     = 32'd98101;
    localparam logic [DATA_W-1:0] GENERATOR_RST   = 32'd2;
    localparam logic [DATA_W-1:0] PRIVATE_KEY_RST = 32'd2;
    localparam logic [DATA_W-1:0] PUBLIC_KEY_RST  = 32'd4;

    localparam logic [IDX_W-1:0] REG_MODULUS     = 2'd0;
    localparam logic [IDX_W-1:0] REG_GENERATOR   = 2'd1;
    localparam logic [IDX_W-1:0] REG_PRIVATE_KEY = 2'd2;
    localparam logic [IDX_W-1:0] REG_PUBLIC_KEY  = 2'd3;

    localparam logic [CMD_W-1:0] CMD_KEYGEN  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ENCRYPT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_DECRYPT = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_POW_RED,
        ST_POW_BIT,
        ST_POW_MUL,
        ST_POW_SQR,
        ST_INV_CHK,
        ST_INV_DIV,
        ST_INV_MUL,
        ST_RED,
        ST_FMUL,
        ST_DONE
    } state_t;

    typedef enum logic [1:0] {
        PH_KEY,
        PH_ENC1,
        PH_ENC2,
        PH_DEC
    } phase_t;

endpackage

// ===== rtl/egc_mulmod.sv =====
// bit-serial modular multiplier, one multiplier bit per cycle
module egc_mulmod #(
    parameter int W = egc_pkg::MOD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] op_a,     // must be below modulus
    input  logic [W-1:0] op_b,
    input  logic [W-1:0] modulus,
    output logic         done,
    output logic [W-1:0] product
);

    logic [W-1:0] acc_reg, acc_next;
    logic [W-1:0] a_reg, a_next;
    logic [W-1:0] b_reg, b_next;
    logic         busy_reg, busy_next;

    function automatic logic [W-1:0] add_mod(input logic [W-1:0] x, input logic [W-1:0] y,
                                             input logic [W-1:0] p);
        logic [W:0] s;
        s = {1'b0, x} + {1'b0, y};
        if (s >= {1'b0, p})
            s = s - {1'b0, p};
        return s[W-1:0];
    endfunction

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        busy_next = busy_reg;
        done      = busy_reg && (b_reg == '0);
        priority if (start)
        begin
            acc_next  = '0;
            a_next    = op_a;
            b_next    = op_b;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg == '0)
                busy_next = 1'b0;
            else
            begin
                if (b_reg[0])
                    acc_next = add_mod(acc_reg, a_reg, modulus);
                a_next = add_mod(a_reg, a_reg, modulus);
                b_next = b_reg >> 1;
            end
        end
        else
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            busy_reg <= 1'b0;
        else
            busy_reg <= busy_next;
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        a_reg   <= a_next;
        b_reg   <= b_next;
    end

    assign product = acc_reg;

endmodule

// ===== rtl/egc_divu.sv =====
// restoring divider, one quotient bit per cycle
module egc_divu #(
    parameter int W = egc_pkg::MOD_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         done,
    output logic [W-1:0] quotient,
    output logic [W-1:0] remainder
);

    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  rem_reg, rem_next;
    logic [W-1:0]  quo_reg, quo_next;
    logic [W-1:0]  dvs_reg, dvs_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [W:0]    trial;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done      = busy_reg && (cnt_reg == '0);
        trial     = {rem_reg, quo_reg[W-1]};
        priority if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CW'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
                busy_next = 1'b0;
            else
            begin
                if (trial >= {1'b0, dvs_reg})
                begin
                    trial    = trial - {1'b0, dvs_reg};
                    quo_next = {quo_reg[W-2:0], 1'b1};
                end
                else
                    quo_next = {quo_reg[W-2:0], 1'b0};
                rem_next = trial[W-1:0];
                cnt_next = cnt_reg - CW'(1);
            end
        end
        else
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

// ===== rtl/elgamal_cipher_core_unit.sv =====
// top level: elgamal key derivation, encryption and decryption sequencer
// One word in, one word out. All arithmetic runs on a single bit-serial modular
// multiplier (one multiplier bit per cycle, W = min(MOD_BITS, 32)) and, for
// decryption, a restoring divider for the euclid steps. An exponentiation costs
// a squaring per exponent bit plus a multiply per set bit, after the base is
// reduced. Key derivation is one exponentiation, encryption two plus a final
// product and decryption one plus up to about 1.5*W euclid steps and a final
// product. The input is not ready while an item is in work; a finished result
// waits in the output register while the next item starts.
module elgamal_cipher_core_unit #(
    parameter int MOD_BITS = egc_pkg::MOD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [63:0]                   s_tdata,   // operand_a, operand_b
    input  logic [egc_pkg::CMD_W-1:0]     s_tuser,   // command
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [63:0]                   m_tdata,   // result_first, result_second
    output logic                          m_tuser,   // status
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [egc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [egc_pkg::DATA_W-1:0]    cfg_data
);

    `include "elgamal_cipher_core_unit_macros.svh"

    localparam int DW = (MOD_BITS < egc_pkg::DATA_W) ? MOD_BITS : egc_pkg::DATA_W;

    logic [egc_pkg::DATA_W-1:0] modulus_reg, generator_reg, private_key_reg, public_key_reg;

    egc_pkg::state_t state_reg, state_next;
    egc_pkg::phase_t phase_reg, phase_next;
    logic [egc_pkg::CMD_W-1:0] cmd_reg, cmd_next;
    logic [DW-1:0] opa_reg, opa_next, opb_reg, opb_next;
    logic [DW-1:0] acc_reg, acc_next, base_reg, base_next, exp_reg, exp_next;
    logic [DW-1:0] r0_reg, r0_next, r1_reg, r1_next, t0_reg, t0_next, t1_reg, t1_next;
    logic [DW-1:0] first_reg, first_next, second_reg, second_next;
    logic          status_reg, status_next;
    logic [egc_pkg::DATA_W-1:0] mfirst_reg, mfirst_next, msecond_reg, msecond_next;
    logic          mstatus_reg, mstatus_next, mvalid_reg, mvalid_next;

    logic [DW-1:0] p_w, g_w, x_w, y_w, in_a, in_b;
    logic          mul_start, mul_done, div_start, div_done;
    logic [DW-1:0] mul_a, mul_b, mul_res, div_quo, div_rem;

    assign p_w  = modulus_reg[DW-1:0];
    assign g_w  = generator_reg[DW-1:0];
    assign x_w  = private_key_reg[DW-1:0];
    assign y_w  = public_key_reg[DW-1:0];
    assign in_a = s_tdata[DW-1:0];
    assign in_b = s_tdata[32+DW-1:32];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            modulus_reg     <= egc_pkg::MODULUS_RST;
            generator_reg   <= egc_pkg::GENERATOR_RST;
            private_key_reg <= egc_pkg::PRIVATE_KEY_RST;
            public_key_reg  <= egc_pkg::PUBLIC_KEY_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                egc_pkg::REG_MODULUS:     modulus_reg     <= cfg_data;
                egc_pkg::REG_GENERATOR:   generator_reg   <= cfg_data;
                egc_pkg::REG_PRIVATE_KEY: private_key_reg <= cfg_data;
                egc_pkg::REG_PUBLIC_KEY:  public_key_reg  <= cfg_data;
            endcase
        end
    end

    egc_mulmod #(.W(DW)) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .op_a    (mul_a),
        .op_b    (mul_b),
        .modulus (p_w),
        .done    (mul_done),
        .product (mul_res)
    );

    egc_divu #(.W(DW)) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (r0_reg),
        .divisor   (r1_reg),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    assign s_tready = (state_reg == egc_pkg::ST_IDLE);

    always_comb
    begin
        state_next   = state_reg;
        phase_next   = phase_reg;
        cmd_next     = cmd_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        acc_next     = acc_reg;
        base_next    = base_reg;
        exp_next     = exp_reg;
        r0_next      = r0_reg;
        r1_next      = r1_reg;
        t0_next      = t0_reg;
        t1_next      = t1_reg;
        first_next   = first_reg;
        second_next  = second_reg;
        status_next  = status_reg;
        mfirst_next  = mfirst_reg;
        msecond_next = msecond_reg;
        mstatus_next = mstatus_reg;
        mvalid_next  = mvalid_reg && !m_tready;
        mul_start    = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        div_start    = 1'b0;

        unique case (state_reg)
            egc_pkg::ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next    = s_tuser;
                    opa_next    = in_a;
                    opb_next    = in_b;
                    first_next  = '0;
                    second_next = '0;
                    status_next = 1'b0;
                    state_next  = egc_pkg::ST_DONE;
                    // modulus of 0 or 1 gives zeros, decrypt flags failure
                    if (p_w < DW'(2))
                        status_next = (s_tuser == egc_pkg::CMD_DECRYPT);
                    else if (s_tuser == egc_pkg::CMD_KEYGEN)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = DW'(1);
                        mul_b      = g_w;
                        exp_next   = x_w;
                        phase_next = egc_pkg::PH_KEY;
                        state_next = egc_pkg::ST_POW_RED;
                    end
                    else if (s_tuser == egc_pkg::CMD_ENCRYPT)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = DW'(1);
                        mul_b      = g_w;
                        exp_next   = in_b;
                        phase_next = egc_pkg::PH_ENC1;
                        state_next = egc_pkg::ST_POW_RED;
                    end
                    else if (s_tuser == egc_pkg::CMD_DECRYPT)
                    begin
                        mul_start  = 1'b1;
                        mul_a      = DW'(1);
                        mul_b      = in_a;
                        exp_next   = x_w;
                        phase_next = egc_pkg::PH_DEC;
                        state_next = egc_pkg::ST_POW_RED;
                    end
                end
            end

            // base reduced mod p as 1 * base
            egc_pkg::ST_POW_RED:
            begin
                if (mul_done)
                begin
                    base_next  = mul_res;
                    acc_next   = DW'(1);
                    state_next = egc_pkg::ST_POW_BIT;
                end
            end

            egc_pkg::ST_POW_BIT:
            begin
                if (exp_reg == '0)
                begin
                    unique case (phase_reg)
                        egc_pkg::PH_KEY:
                        begin
                            first_next = acc_reg;
                            state_next = egc_pkg::ST_DONE;
                        end
                        egc_pkg::PH_ENC1:
                        begin
                            first_next = acc_reg;
                            exp_next   = opb_reg;
                            phase_next = egc_pkg::PH_ENC2;
                            mul_start  = 1'b1;
                            mul_a      = DW'(1);
                            mul_b      = y_w;
                            state_next = egc_pkg::ST_POW_RED;
                        end
                        egc_pkg::PH_ENC2:
                        begin
                            mul_start  = 1'b1;
                            mul_a      = DW'(1);
                            mul_b      = opa_reg;
                            state_next = egc_pkg::ST_RED;
                        end
                        egc_pkg::PH_DEC:
                        begin
                            r0_next    = p_w;
                            r1_next    = acc_reg;
                            t0_next    = '0;
                            t1_next    = DW'(1);
                            state_next = egc_pkg::ST_INV_CHK;
                        end
                    endcase
                end
                else if (exp_reg[0])
                begin
                    mul_start  = 1'b1;
                    mul_a      = acc_reg;
                    mul_b      = base_reg;
                    state_next = egc_pkg::ST_POW_MUL;
                end
                else
                begin
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    mul_b      = base_reg;
                    state_next = egc_pkg::ST_POW_SQR;
                end
            end

            egc_pkg::ST_POW_MUL:
            begin
                if (mul_done)
                begin
                    acc_next   = mul_res;
                    mul_start  = 1'b1;
                    mul_a      = base_reg;
                    mul_b      = base_reg;
                    state_next = egc_pkg::ST_POW_SQR;
                end
            end

            egc_pkg::ST_POW_SQR:
            begin
                if (mul_done)
                begin
                    base_next  = mul_res;
                    exp_next   = exp_reg >> 1;
                    state_next = egc_pkg::ST_POW_BIT;
                end
            end

            egc_pkg::ST_INV_CHK:
            begin
                if (r1_reg == '0)
                begin
                    if (r0_reg == DW'(1))
                    begin
                        acc_next   = t0_reg;
                        mul_start  = 1'b1;
                        mul_a      = DW'(1);
                        mul_b      = opb_reg;
                        state_next = egc_pkg::ST_RED;
                    end
                    else
                    begin
                        status_next = 1'b1;
                        state_next  = egc_pkg::ST_DONE;
                    end
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = egc_pkg::ST_INV_DIV;
                end
            end

            egc_pkg::ST_INV_DIV:
            begin
                if (div_done)
                begin
                    r0_next    = r1_reg;
                    r1_next    = div_rem;
                    mul_start  = 1'b1;
                    mul_a      = t1_reg;
                    mul_b      = div_quo;
                    state_next = egc_pkg::ST_INV_MUL;
                end
            end

            egc_pkg::ST_INV_MUL:
            begin
                if (mul_done)
                begin
                    // t0 - q*t1 mod p, wraps back into range on borrow
                    if (t0_reg >= mul_res)
                        t1_next = t0_reg - mul_res;
                    else
                        t1_next = t0_reg - mul_res + p_w;
                    t0_next    = t1_reg;
                    state_next = egc_pkg::ST_INV_CHK;
                end
            end

            egc_pkg::ST_RED:
            begin
                if (mul_done)
                begin
                    mul_start  = 1'b1;
                    mul_a      = mul_res;
                    mul_b      = acc_reg;
                    state_next = egc_pkg::ST_FMUL;
                end
            end

            egc_pkg::ST_FMUL:
            begin
                if (mul_done)
                begin
                    if (cmd_reg == egc_pkg::CMD_ENCRYPT)
                        second_next = mul_res;
                    else
                        first_next = mul_res;
                    state_next = egc_pkg::ST_DONE;
                end
            end

            egc_pkg::ST_DONE:
            begin
                if (!mvalid_reg || m_tready)
                begin
                    mfirst_next  = egc_pkg::DATA_W'(first_reg);
                    msecond_next = egc_pkg::DATA_W'(second_reg);
                    mstatus_next = status_reg;
                    mvalid_next  = 1'b1;
                    state_next   = egc_pkg::ST_IDLE;
                end
            end

            default:
                state_next = egc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= egc_pkg::ST_IDLE;
            phase_reg  <= egc_pkg::PH_KEY;
            mvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase_reg  <= phase_next;
            mvalid_reg <= mvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        opa_reg     <= opa_next;
        opb_reg     <= opb_next;
        acc_reg     <= acc_next;
        base_reg    <= base_next;
        exp_reg     <= exp_next;
        r0_reg      <= r0_next;
        r1_reg      <= r1_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        first_reg   <= first_next;
        second_reg  <= second_next;
        status_reg  <= status_next;
        mfirst_reg  <= mfirst_next;
        msecond_reg <= msecond_next;
        mstatus_reg <= mstatus_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {msecond_reg, mfirst_reg};
    assign m_tuser  = mstatus_reg;

    `EGC_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "ready after accept")
    `EGC_ASSERT_SAME(a_units_exclusive, 1'b1, !(mul_done && div_done), "both units done")
    `EGC_ASSERT_SAME(a_out_from_done, $rose(mvalid_reg), $past(state_reg) == egc_pkg::ST_DONE, "stray result")
    `EGC_ASSERT_SAME(a_fail_zero, m_tvalid && m_tuser, m_tdata[31:0] == 32'd0, "failed result nonzero")

endmodule
